// ===== design/ecrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecrfc_pkg: EtherCAT response frame checker package
// Shared types, frame layout constants and verdict codes.
// ----------------------------------------------------------------------------
package ecrfc_pkg;

    localparam logic [11:0] MAX_FRAME  = 12'd1518;
    localparam int          NUM_SLOTS  = 16;
    localparam logic [10:0] COUNT_SAT  = 11'd2047;
    localparam logic [11:0] MIN_FRAME  = 12'd28;
    localparam logic [11:0] MIN_LENGTH = 12'd12;

    localparam logic [7:0]  ETH_TYPE_HI = 8'h88;
    localparam logic [7:0]  ETH_TYPE_LO = 8'hA4;

    localparam logic [10:0] POS_FIRST    = 11'd0;
    localparam logic [10:0] POS_TYPE_HI  = 11'd12;
    localparam logic [10:0] POS_TYPE_LO  = 11'd13;
    localparam logic [10:0] POS_LEN_LO   = 11'd14;
    localparam logic [10:0] POS_LEN_HI   = 11'd15;
    localparam logic [10:0] POS_WKC_MIN  = 11'd16;
    localparam logic [10:0] POS_INDEX    = 11'd17;
    localparam logic [12:0] WKC_LO_OFS   = 13'd14;
    localparam logic [12:0] WKC_HI_OFS   = 13'd15;
    localparam logic [12:0] HEADER_BYTES = 13'd14;
    localparam logic [12:0] WKC_BYTES    = 13'd2;

    typedef enum logic [2:0] {
        VERDICT_MATCH     = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_NOT_ECAT  = 3'd2,
        VERDICT_INDEX     = 3'd3,
        VERDICT_BAD_LEN   = 3'd4,
        VERDICT_OVERSIZE  = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
        logic [3:0] expected_index;
    } in_item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [15:0] work_counter;
        logic [11:0] payload_length;
        logic [7:0]  seen_index;
        logic [10:0] frame_bytes;
    } result_t;

endpackage

// ===== design/ecrfc_in_stage.sv =====
// ----------------------------------------------------------------------------
// ecrfc_in_stage: input register
// Registers one received byte item and handshakes with the upstream source.
// ----------------------------------------------------------------------------
module ecrfc_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ecrfc_pkg::in_item_t s_item,
    input  logic                proc_fire,
    output logic                in_valid,
    output ecrfc_pkg::in_item_t in_item
);

    logic                valid_reg;
    ecrfc_pkg::in_item_t item_reg;

    assign s_ready  = !valid_reg || proc_fire;
    assign in_valid = valid_reg;
    assign in_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== design/ecrfc_core.sv =====
// ----------------------------------------------------------------------------
// ecrfc_core: per-frame state and verdict logic
// Tracks byte position, captures header fields and the working counter,
// and forms the verdict on the last byte of each frame.
// ----------------------------------------------------------------------------
module ecrfc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                proc_fire,
    input  ecrfc_pkg::in_item_t in_item,
    output logic                res_valid,
    output ecrfc_pkg::result_t  res
);

    logic [10:0] byte_count_reg;
    logic [3:0]  held_index_reg;
    logic        type_ok_reg;
    logic [7:0]  found_index_reg;
    logic [11:0] length_field_reg;
    logic [15:0] counter_value_reg;

    logic [3:0]  held_index_next;
    logic        type_ok_next;
    logic [7:0]  found_index_next;
    logic [11:0] length_field_next;
    logic [15:0] counter_value_next;
    logic [10:0] byte_count_next;

    logic [10:0] pos;
    logic [12:0] pos_w;
    logic [7:0]  b;
    logic [11:0] total;
    logic        len_ok;
    ecrfc_pkg::verdict_t verdict;

    assign pos   = byte_count_reg;
    assign pos_w = {2'b0, pos};
    assign b     = in_item.rx_byte;
    assign total = {1'b0, pos} + 12'd1;

    always_comb begin
        held_index_next    = held_index_reg;
        type_ok_next       = type_ok_reg;
        found_index_next   = found_index_reg;
        length_field_next  = length_field_reg;
        counter_value_next = counter_value_reg;

        if (pos == ecrfc_pkg::POS_FIRST) begin
            held_index_next = in_item.expected_index;
        end

        case (pos)
            ecrfc_pkg::POS_TYPE_HI: type_ok_next = (b == ecrfc_pkg::ETH_TYPE_HI);
            ecrfc_pkg::POS_TYPE_LO: type_ok_next = type_ok_reg && (b == ecrfc_pkg::ETH_TYPE_LO);
            ecrfc_pkg::POS_LEN_LO:  length_field_next = {length_field_reg[11:8], b};
            ecrfc_pkg::POS_LEN_HI:  length_field_next = {b[3:0], length_field_reg[7:0]};
            ecrfc_pkg::POS_INDEX:   found_index_next = b;
            default: ;
        endcase

        if (pos >= ecrfc_pkg::POS_WKC_MIN) begin
            if (pos_w == ecrfc_pkg::WKC_LO_OFS + {1'b0, length_field_reg}) begin
                counter_value_next = {counter_value_reg[15:8], b};
            end else if (pos_w == ecrfc_pkg::WKC_HI_OFS + {1'b0, length_field_reg}) begin
                counter_value_next = {b, counter_value_reg[7:0]};
            end
        end

        byte_count_next = (pos < ecrfc_pkg::COUNT_SAT) ? pos + 11'd1 : pos;
    end

    always_comb begin
        len_ok = (length_field_next >= ecrfc_pkg::MIN_LENGTH) &&
                 (({1'b0, length_field_next} + ecrfc_pkg::WKC_BYTES) <=
                  ({1'b0, total} - ecrfc_pkg::HEADER_BYTES));

        if (total > ecrfc_pkg::MAX_FRAME) begin
            verdict = ecrfc_pkg::VERDICT_OVERSIZE;
        end else if (total < ecrfc_pkg::MIN_FRAME) begin
            verdict = ecrfc_pkg::VERDICT_SHORT;
        end else if (!type_ok_next) begin
            verdict = ecrfc_pkg::VERDICT_NOT_ECAT;
        end else if ((32'(held_index_next) >= ecrfc_pkg::NUM_SLOTS) ||
                     (found_index_next != {4'b0, held_index_next})) begin
            verdict = ecrfc_pkg::VERDICT_INDEX;
        end else if (!len_ok) begin
            verdict = ecrfc_pkg::VERDICT_BAD_LEN;
        end else begin
            verdict = ecrfc_pkg::VERDICT_MATCH;
        end

        res.verdict        = verdict;
        res.work_counter   = (verdict == ecrfc_pkg::VERDICT_MATCH) ? counter_value_next : 16'd0;
        res.payload_length = length_field_next;
        res.seen_index     = found_index_next;
        res.frame_bytes    = (total > {1'b0, ecrfc_pkg::COUNT_SAT}) ? ecrfc_pkg::COUNT_SAT
                                                                     : total[10:0];
    end

    assign res_valid = proc_fire && in_item.frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn || res_valid) begin
            byte_count_reg    <= '0;
            held_index_reg    <= '0;
            type_ok_reg       <= 1'b0;
            found_index_reg   <= '0;
            length_field_reg  <= '0;
            counter_value_reg <= '0;
        end else if (proc_fire) begin
            byte_count_reg    <= byte_count_next;
            held_index_reg    <= held_index_next;
            type_ok_reg       <= type_ok_next;
            found_index_reg   <= found_index_next;
            length_field_reg  <= length_field_next;
            counter_value_reg <= counter_value_next;
        end
    end

endmodule

// ===== design/ecrfc_out_stage.sv =====
// ----------------------------------------------------------------------------
// ecrfc_out_stage: result register
// Holds one verdict item until the downstream sink takes it.
// ----------------------------------------------------------------------------
module ecrfc_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               res_valid,
    input  ecrfc_pkg::result_t res,
    output logic               out_free,
    output logic               m_valid,
    input  logic               m_ready,
    output ecrfc_pkg::result_t m_res
);

    logic               valid_reg;
    ecrfc_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

// ===== design/ethercat_response_frame_checker.sv =====
// Path: the last byte of a frame passes the input register, and its verdict item is held in the result register.
// Throughput: one byte per cycle; a last byte waits only while the previous verdict
// is still held in the result register.
// Reset: synchronous active-low aresetn clears the byte count, captured header fields,
// and both valid flags; the next byte accepted starts a new frame.
// ----------------------------------------------------------------------------
// ethercat_response_frame_checker: EtherCAT response frame checker
// Checks a received Ethernet frame byte by byte and gives one verdict per frame.
// ----------------------------------------------------------------------------
module ethercat_response_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_frame_end,
    input  logic [3:0]  s_expected_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic [15:0] m_work_counter,
    output logic [11:0] m_payload_length,
    output logic [7:0]  m_seen_index,
    output logic [10:0] m_frame_bytes
);

    ecrfc_pkg::in_item_t s_item;
    ecrfc_pkg::in_item_t in_item;
    ecrfc_pkg::result_t  res;
    ecrfc_pkg::result_t  m_res;
    logic                in_valid;
    logic                proc_fire;
    logic                res_valid;
    logic                out_free;

    assign s_item.rx_byte        = s_rx_byte;
    assign s_item.frame_end      = s_frame_end;
    assign s_item.expected_index = s_expected_index;

    assign proc_fire = in_valid && (!in_item.frame_end || out_free);

    ecrfc_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .proc_fire (proc_fire),
        .in_valid  (in_valid),
        .in_item   (in_item)
    );

    ecrfc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .proc_fire (proc_fire),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res       (res)
    );

    ecrfc_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_verdict        = m_res.verdict;
    assign m_work_counter   = m_res.work_counter;
    assign m_payload_length = m_res.payload_length;
    assign m_seen_index     = m_res.seen_index;
    assign m_frame_bytes    = m_res.frame_bytes;

endmodule

// ===== design/ecrfc_checker.sv =====
// ----------------------------------------------------------------------------
// ecrfc_checker: port-level checks for the frame checker
// Watches the result channel for consistent verdict items.
// ----------------------------------------------------------------------------
module ecrfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_verdict,
    input logic [15:0] m_work_counter,
    input logic [11:0] m_payload_length,
    input logic [10:0] m_frame_bytes
);

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict) && $stable(m_work_counter))
        else $error("stalled result item changed");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_verdict <= 3'(ecrfc_pkg::VERDICT_OVERSIZE))
        else $error("verdict code out of range");

    a_match_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == 3'(ecrfc_pkg::VERDICT_MATCH)) |->
        (m_frame_bytes >= 11'd28) && (m_payload_length >= 12'd12))
        else $error("match on short frame or short length");

    a_wkc_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict != 3'(ecrfc_pkg::VERDICT_MATCH)) |-> m_work_counter == 16'd0)
        else $error("working counter on failed frame");

endmodule

bind ethercat_response_frame_checker ecrfc_checker u_ecrfc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_verdict        (m_verdict),
    .m_work_counter   (m_work_counter),
    .m_payload_length (m_payload_length),
    .m_frame_bytes    (m_frame_bytes)
);
